### rtl/tic_pkg.sv
// ----------------------------------------------------------------------------
// TIFF directory entry classifier package
// Shared widths, codes, tag numbers, queue and result types, and the small
// decode functions used by the front and back parts of the classifier.
// ----------------------------------------------------------------------------
package tic_pkg;

  localparam int MAX_ENTRIES_DEF = 512;

  localparam int OP_W      = 2;
  localparam int WORD_W    = 32;
  localparam int HALF_W    = 16;
  localparam int STATUS_W  = 3;
  localparam int SLOT_W    = 4;
  localparam int TYPE_W    = 16;
  localparam int COUNT_W   = 32;
  localparam int FSIZE_W   = 40;
  localparam int DOFF_W    = 40;
  localparam int DBYTES_W  = 35;
  // Directory positions: a 32-bit start plus a bounded directory length.
  localparam int ENT_OFF_W = 33;
  localparam int Q_DEPTH   = 2;

  // File layout constants in bytes.
  localparam int MIN_FILE_SIZE   = 8;
  localparam int COUNT_BYTES     = 2;
  localparam int ENTRY_BYTES     = 12;
  localparam int NEXT_PTR_BYTES  = 4;
  localparam int VALUE_FIELD_OFS = 8;
  localparam int INLINE_MAX      = 4;

  localparam logic [7:0]  BOM_LITTLE    = 8'h49;
  localparam logic [7:0]  BOM_BIG       = 8'h4D;
  localparam logic [15:0] TIFF_MAGIC    = 16'd42;
  localparam logic [15:0] BIGTIFF_MAGIC = 16'd43;

  // Field type codes.
  localparam logic [15:0] TYPE_BYTE      = 16'd1;
  localparam logic [15:0] TYPE_ASCII     = 16'd2;
  localparam logic [15:0] TYPE_SHORT     = 16'd3;
  localparam logic [15:0] TYPE_LONG      = 16'd4;
  localparam logic [15:0] TYPE_RATIONAL  = 16'd5;
  localparam logic [15:0] TYPE_SBYTE     = 16'd6;
  localparam logic [15:0] TYPE_UNDEFINED = 16'd7;
  localparam logic [15:0] TYPE_SSHORT    = 16'd8;
  localparam logic [15:0] TYPE_SLONG     = 16'd9;
  localparam logic [15:0] TYPE_SRATIONAL = 16'd10;
  localparam logic [15:0] TYPE_FLOAT     = 16'd11;
  localparam logic [15:0] TYPE_DOUBLE    = 16'd12;

  // Colour tags that get a slot of their own.
  localparam logic [15:0] TAG_COLOR_MATRIX1      = 16'd50721;
  localparam logic [15:0] TAG_CAMERA_CAL1        = 16'd50723;
  localparam logic [15:0] TAG_ANALOG_BALANCE     = 16'd50727;
  localparam logic [15:0] TAG_AS_SHOT_NEUTRAL    = 16'd50728;
  localparam logic [15:0] TAG_CAMERA_CAL_SIG     = 16'd50931;
  localparam logic [15:0] TAG_PROFILE_CAL_SIG    = 16'd50932;
  localparam logic [15:0] TAG_FORWARD_MATRIX1    = 16'd50964;
  // Second and third calibration tags.
  localparam logic [15:0] TAG_COLOR_MATRIX2      = 16'd50722;
  localparam logic [15:0] TAG_CAMERA_CAL2        = 16'd50724;
  localparam logic [15:0] TAG_REDUCTION_MATRIX2  = 16'd50726;
  localparam logic [15:0] TAG_CAL_ILLUMINANT2    = 16'd50779;
  localparam logic [15:0] TAG_FORWARD_MATRIX2    = 16'd50965;
  localparam logic [15:0] TAG_CAL_ILLUMINANT3    = 16'd52529;
  localparam logic [15:0] TAG_CAMERA_CAL3        = 16'd52530;
  localparam logic [15:0] TAG_COLOR_MATRIX3      = 16'd52531;
  localparam logic [15:0] TAG_FORWARD_MATRIX3    = 16'd52532;
  localparam logic [15:0] TAG_REDUCTION_MATRIX3  = 16'd52538;

  localparam logic [SLOT_W-1:0] SLOT_NONE            = 4'd0;
  localparam logic [SLOT_W-1:0] SLOT_COLOR_MATRIX1   = 4'd1;
  localparam logic [SLOT_W-1:0] SLOT_CAMERA_CAL1     = 4'd2;
  localparam logic [SLOT_W-1:0] SLOT_ANALOG_BALANCE  = 4'd3;
  localparam logic [SLOT_W-1:0] SLOT_AS_SHOT_NEUTRAL = 4'd4;
  localparam logic [SLOT_W-1:0] SLOT_CAMERA_CAL_SIG  = 4'd5;
  localparam logic [SLOT_W-1:0] SLOT_PROFILE_CAL_SIG = 4'd6;
  localparam logic [SLOT_W-1:0] SLOT_FORWARD_MATRIX1 = 4'd7;
  localparam logic [SLOT_W-1:0] SLOT_EXTRA_CAL       = 4'd8;

  typedef enum logic [OP_W-1:0] {
    OP_HEADER = 2'd0,
    OP_COUNT  = 2'd1,
    OP_ENTRY  = 2'd2
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 3'd0,
    ST_INVALID    = 3'd1,
    ST_BIGTIFF    = 3'd2,
    ST_BAD_OFFSET = 3'd3,
    ST_CAP        = 3'd4,
    ST_TRUNCATED  = 3'd5,
    ST_RANGE      = 3'd6,
    ST_SEQUENCE   = 3'd7
  } status_t;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_COUNT  = 2'd1,
    PH_ENTRY  = 2'd2,
    PH_DONE   = 2'd3
  } phase_t;

  // Size of one value of a field type, as a shift amount.
  typedef struct packed {
    logic       known;
    logic [1:0] shift;
  } type_info_t;

  // One pre-decoded item as it waits between the front and back parts.
  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [WORD_W-1:0] w0;
    logic [WORD_W-1:0] w1;
    logic [WORD_W-1:0] w2;
    logic [SLOT_W-1:0] slot_le;
    logic [SLOT_W-1:0] slot_be;
    type_info_t        tinfo_le;
    type_info_t        tinfo_be;
    status_t           hdr_status;
    logic              hdr_bom_ok;
    logic              hdr_little;
  } q_item_t;

  typedef struct packed {
    status_t             status;
    logic [SLOT_W-1:0]   slot;
    logic [TYPE_W-1:0]   field_type;
    logic [COUNT_W-1:0]  item_count;
    logic [DOFF_W-1:0]   data_offset;
    logic [DBYTES_W-1:0] data_bytes;
    logic                multi_cal_seen;
    logic                last;
  } result_t;

  // First two bytes of a word in the given byte order.
  function automatic logic [HALF_W-1:0] get16(input logic [WORD_W-1:0] w, input logic lit);
    return lit ? {w[23:16], w[31:24]} : w[31:16];
  endfunction

  // Last two bytes of a word in the given byte order.
  function automatic logic [HALF_W-1:0] get16b(input logic [WORD_W-1:0] w, input logic lit);
    return lit ? {w[7:0], w[15:8]} : w[15:0];
  endfunction

  function automatic logic [WORD_W-1:0] get32(input logic [WORD_W-1:0] w, input logic lit);
    return lit ? {w[7:0], w[15:8], w[23:16], w[31:24]} : w;
  endfunction

  function automatic type_info_t type_info(input logic [TYPE_W-1:0] t);
    type_info_t r;
    r = '0;
    unique case (t) inside
      TYPE_BYTE, TYPE_ASCII, TYPE_SBYTE, TYPE_UNDEFINED: r = '{known: 1'b1, shift: 2'd0};
      TYPE_SHORT, TYPE_SSHORT:                           r = '{known: 1'b1, shift: 2'd1};
      TYPE_LONG, TYPE_SLONG, TYPE_FLOAT:                 r = '{known: 1'b1, shift: 2'd2};
      TYPE_RATIONAL, TYPE_SRATIONAL, TYPE_DOUBLE:        r = '{known: 1'b1, shift: 2'd3};
      default:                                           r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [SLOT_W-1:0] classify(input logic [HALF_W-1:0] tag);
    logic [SLOT_W-1:0] s;
    s = SLOT_NONE;
    unique case (tag) inside
      TAG_COLOR_MATRIX1:   s = SLOT_COLOR_MATRIX1;
      TAG_CAMERA_CAL1:     s = SLOT_CAMERA_CAL1;
      TAG_ANALOG_BALANCE:  s = SLOT_ANALOG_BALANCE;
      TAG_AS_SHOT_NEUTRAL: s = SLOT_AS_SHOT_NEUTRAL;
      TAG_CAMERA_CAL_SIG:  s = SLOT_CAMERA_CAL_SIG;
      TAG_PROFILE_CAL_SIG: s = SLOT_PROFILE_CAL_SIG;
      TAG_FORWARD_MATRIX1: s = SLOT_FORWARD_MATRIX1;
      TAG_COLOR_MATRIX2, TAG_CAMERA_CAL2, TAG_REDUCTION_MATRIX2, TAG_CAL_ILLUMINANT2,
      TAG_FORWARD_MATRIX2, TAG_CAL_ILLUMINANT3, TAG_CAMERA_CAL3, TAG_COLOR_MATRIX3,
      TAG_FORWARD_MATRIX3, TAG_REDUCTION_MATRIX3: s = SLOT_EXTRA_CAL;
      default:             s = SLOT_NONE;
    endcase
    return s;
  endfunction

endpackage

### rtl/tic_item_if.sv
// ----------------------------------------------------------------------------
// Input item channel
// Valid/ready channel carrying one header, count or directory entry item.
// ----------------------------------------------------------------------------
interface tic_item_if;
  import tic_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [WORD_W-1:0] raw_word0;
  logic [WORD_W-1:0] raw_word1;
  logic [WORD_W-1:0] raw_word2;

  modport source (output valid, op, raw_word0, raw_word1, raw_word2, input ready);
  modport sink   (input valid, op, raw_word0, raw_word1, raw_word2, output ready);
endinterface

### rtl/tic_result_if.sv
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one classification result per item.
// ----------------------------------------------------------------------------
interface tic_result_if;
  import tic_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [SLOT_W-1:0]   slot;
  logic [TYPE_W-1:0]   field_type;
  logic [COUNT_W-1:0]  item_count;
  logic [DOFF_W-1:0]   data_offset;
  logic [DBYTES_W-1:0] data_bytes;
  logic                multi_cal_seen;
  logic                last;

  modport source (output valid, status, slot, field_type, item_count, data_offset,
                  data_bytes, multi_cal_seen, last, input ready);
  modport sink   (input valid, status, slot, field_type, item_count, data_offset,
                  data_bytes, multi_cal_seen, last, output ready);
endinterface

### rtl/tic_front.sv
// ----------------------------------------------------------------------------
// Classifier front end
// Accepts items and pre-decodes everything that does not depend on parser
// state: header checks, and tag slot and type size for both byte orders.
// ----------------------------------------------------------------------------
module tic_front (
  tic_item_if.sink           items,
  input  logic               q_full,
  output logic               push_valid,
  output tic_pkg::q_item_t   push_data
);
  import tic_pkg::*;

  logic [7:0]        bom0;
  logic [7:0]        bom1;
  logic              bom_ok;
  logic              bom_little;
  logic [HALF_W-1:0] magic;

  assign items.ready = !q_full;
  assign push_valid  = items.valid;

  // The header carries its own byte order, so its checks need no state.
  assign bom0       = items.raw_word0[31:24];
  assign bom1       = items.raw_word0[23:16];
  assign bom_little = (bom0 == BOM_LITTLE);
  assign bom_ok     = (bom0 == bom1) && ((bom0 == BOM_LITTLE) || (bom0 == BOM_BIG));
  assign magic      = get16b(items.raw_word0, bom_little);

  always_comb begin
    push_data            = '0;
    push_data.op         = items.op;
    push_data.w0         = items.raw_word0;
    push_data.w1         = items.raw_word1;
    push_data.w2         = items.raw_word2;
    push_data.slot_le    = classify(get16(items.raw_word0, 1'b1));
    push_data.slot_be    = classify(get16(items.raw_word0, 1'b0));
    push_data.tinfo_le   = type_info(get16b(items.raw_word0, 1'b1));
    push_data.tinfo_be   = type_info(get16b(items.raw_word0, 1'b0));
    push_data.hdr_bom_ok = bom_ok;
    push_data.hdr_little = bom_little;
    if (!bom_ok) begin
      push_data.hdr_status = ST_INVALID;
    end else if (magic == BIGTIFF_MAGIC) begin
      push_data.hdr_status = ST_BIGTIFF;
    end else if (magic != TIFF_MAGIC) begin
      push_data.hdr_status = ST_INVALID;
    end else begin
      push_data.hdr_status = ST_OK;
    end
  end

endmodule

### rtl/tic_queue.sv
// ----------------------------------------------------------------------------
// Classifier item queue
// Short register queue between the front end and the back end.
// ----------------------------------------------------------------------------
module tic_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  input  tic_pkg::q_item_t push_data,
  output logic             full,
  input  logic             pop,
  output logic             pop_valid,
  output tic_pkg::q_item_t pop_data
);
  import tic_pkg::*;

  localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CNT_W = $clog2(Q_DEPTH + 1);

  q_item_t           entries [Q_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  fill;
  logic              do_push;
  logic              do_pop;

  assign full      = (fill == CNT_W'(Q_DEPTH));
  assign pop_valid = (fill != '0);
  assign pop_data  = entries[rd_ptr];
  assign do_push   = push_valid && !full;
  assign do_pop    = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - CNT_W'(1);
      end
    end
  end

endmodule

### rtl/tic_back.sv
// ----------------------------------------------------------------------------
// Classifier back end
// Holds the parser state, runs the bound checks, and keeps the result in an
// output register, which stalls the back end while a result waits.
// ----------------------------------------------------------------------------
module tic_back #(
  parameter int MAX_ENTRIES = tic_pkg::MAX_ENTRIES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          file_size_we,
  input  logic [tic_pkg::FSIZE_W-1:0]   file_size_wdata,
  input  logic                          q_valid,
  input  tic_pkg::q_item_t              q_data,
  output logic                          q_pop,
  tic_result_if.source                  results
);
  import tic_pkg::*;

  localparam int ENT_W = $clog2(MAX_ENTRIES + 1);
  localparam logic [HALF_W-1:0] MAX_COUNT = HALF_W'(MAX_ENTRIES);

  logic [FSIZE_W-1:0]   file_size;
  phase_t               phase;
  phase_t               phase_next;
  logic                 little_order;
  logic                 little_next;
  logic [WORD_W-1:0]    dir_start;
  logic [WORD_W-1:0]    dir_start_next;
  logic [ENT_W-1:0]     entries_left;
  logic [ENT_W-1:0]     entries_left_next;
  logic [ENT_OFF_W-1:0] ent_off;
  logic [ENT_OFF_W-1:0] ent_off_next;
  logic                 calib_flag;
  logic                 calib_next;
  logic                 out_valid;
  result_t              result;
  result_t              result_next;

  logic                 step;
  logic                 seq_err;
  logic [HALF_W-1:0]    count_val;
  logic [19:0]          count_x12;
  logic [ENT_OFF_W-1:0] dir_end;
  logic [WORD_W-1:0]    root;
  logic [ENT_OFF_W-1:0] root_end;
  logic [TYPE_W-1:0]    ftype;
  logic [COUNT_W-1:0]   icount;
  type_info_t           tinfo;
  logic [SLOT_W-1:0]    slot_sel;
  logic [DBYTES_W-1:0]  dbytes;
  logic [DOFF_W-1:0]    doff;
  logic [DOFF_W:0]      end_sum;
  logic                 range_err;

  // The back end moves when an item waits and the output register is free or being emptied.
  assign step  = q_valid && (!out_valid || results.ready);
  assign q_pop = step;

  // Count item: directory must fit with its count field and next pointer.
  assign count_val = get16(q_data.w0, little_order);
  assign count_x12 = {1'b0, count_val, 3'b000} + {2'b00, count_val, 2'b00};
  assign dir_end   = ENT_OFF_W'(dir_start) + ENT_OFF_W'(COUNT_BYTES + NEXT_PTR_BYTES)
                   + ENT_OFF_W'(count_x12);

  // Header: the root directory needs room for at least its count field.
  assign root     = get32(q_data.w1, q_data.hdr_little);
  assign root_end = ENT_OFF_W'(root) + ENT_OFF_W'(COUNT_BYTES);

  // Entry decode in the current byte order.
  assign ftype    = get16b(q_data.w0, little_order);
  assign icount   = get32(q_data.w1, little_order);
  assign tinfo    = little_order ? q_data.tinfo_le : q_data.tinfo_be;
  assign slot_sel = little_order ? q_data.slot_le : q_data.slot_be;
  assign dbytes   = tinfo.known ? (DBYTES_W'(icount) << tinfo.shift) : '0;
  assign doff     = (dbytes <= DBYTES_W'(INLINE_MAX)) ? DOFF_W'(ent_off)
                                                      : DOFF_W'(get32(q_data.w2, little_order));
  // The payload fits exactly when its end does not pass the file end.
  assign end_sum   = {1'b0, doff} + (DOFF_W + 1)'(dbytes);
  assign range_err = end_sum > {1'b0, file_size};

  always_comb begin
    phase_next        = phase;
    little_next       = little_order;
    dir_start_next    = dir_start;
    entries_left_next = entries_left;
    ent_off_next      = ent_off;
    calib_next        = calib_flag;
    seq_err           = 1'b0;
    result_next       = '0;
    if (step) begin
      unique case (op_t'(q_data.op))
        OP_HEADER: begin
          calib_next        = 1'b0;
          entries_left_next = '0;
          phase_next        = PH_DONE;
          result_next.last  = 1'b1;
          if (file_size < FSIZE_W'(MIN_FILE_SIZE)) begin
            result_next.status = ST_TRUNCATED;
          end else begin
            if (q_data.hdr_bom_ok) begin
              little_next = q_data.hdr_little;
            end
            if (q_data.hdr_status != ST_OK) begin
              result_next.status = q_data.hdr_status;
            end else if ((root == '0) || (FSIZE_W'(root_end) > file_size)) begin
              result_next.status = ST_BAD_OFFSET;
            end else begin
              dir_start_next   = root;
              phase_next       = PH_COUNT;
              result_next.last = 1'b0;
            end
          end
        end
        OP_COUNT: begin
          if (phase == PH_COUNT) begin
            result_next.item_count = COUNT_W'(count_val);
            phase_next             = PH_DONE;
            result_next.last       = 1'b1;
            if (count_val > MAX_COUNT) begin
              result_next.status = ST_CAP;
            end else if (FSIZE_W'(dir_end) > file_size) begin
              result_next.status = ST_TRUNCATED;
            end else if (count_val != '0) begin
              entries_left_next = ENT_W'(count_val);
              ent_off_next      = ENT_OFF_W'(dir_start)
                                + ENT_OFF_W'(COUNT_BYTES + VALUE_FIELD_OFS);
              phase_next        = PH_ENTRY;
              result_next.last  = 1'b0;
            end
          end else begin
            seq_err = 1'b1;
          end
        end
        OP_ENTRY: begin
          if (phase == PH_ENTRY) begin
            result_next.field_type = ftype;
            result_next.item_count = icount;
            if (tinfo.known) begin
              result_next.data_bytes  = dbytes;
              result_next.data_offset = doff;
            end
            if (tinfo.known && range_err) begin
              result_next.status = ST_RANGE;
              phase_next         = PH_DONE;
              result_next.last   = 1'b1;
            end else begin
              if (tinfo.known) begin
                result_next.slot = slot_sel;
                if (slot_sel == SLOT_EXTRA_CAL) begin
                  calib_next = 1'b1;
                end
              end
              entries_left_next = entries_left - ENT_W'(1);
              ent_off_next      = ent_off + ENT_OFF_W'(ENTRY_BYTES);
              if (entries_left == ENT_W'(1)) begin
                phase_next       = PH_DONE;
                result_next.last = 1'b1;
              end
            end
          end else begin
            seq_err = 1'b1;
          end
        end
        default: begin
          seq_err = 1'b1;
        end
      endcase
      if (seq_err) begin
        result_next        = '0;
        result_next.status = ST_SEQUENCE;
        result_next.last   = 1'b1;
        phase_next         = PH_DONE;
      end
      result_next.multi_cal_seen = calib_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HEADER;
    end else begin
      phase <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      file_size    <= '0;
      little_order <= 1'b1;
      dir_start    <= '0;
      entries_left <= '0;
      ent_off      <= '0;
      calib_flag   <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (file_size_we) begin
        file_size <= file_size_wdata;
      end
      little_order <= little_next;
      dir_start    <= dir_start_next;
      entries_left <= entries_left_next;
      ent_off      <= ent_off_next;
      calib_flag   <= calib_next;
      if (step) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      result <= result_next;
    end
  end

  assign results.valid          = out_valid;
  assign results.status         = result.status;
  assign results.slot           = result.slot;
  assign results.field_type     = result.field_type;
  assign results.item_count     = result.item_count;
  assign results.data_offset    = result.data_offset;
  assign results.data_bytes     = result.data_bytes;
  assign results.multi_cal_seen = result.multi_cal_seen;
  assign results.last           = result.last;

endmodule

### rtl/tiff_ifd_entry_classifier.sv
// ----------------------------------------------------------------------------
// TIFF first-directory entry classifier
// Parses the classic TIFF header, the entry count and the 12-byte entries of
// the first directory, and classifies colour and calibration tags.
// ----------------------------------------------------------------------------
// Usage:
//   items carries the header, then the entry count, then one directory entry
//   per transfer. results returns exactly one result per item, in order.
//   file_size is written through file_size_we/file_size_wdata while the block
//   is idle; the header, count and entry range checks use it.
// Flow and throughput:
//   An item is registered in the two-entry queue behind the front end when it
//   transfers; the back end then takes it from the queue and writes the output
//   register, from which its result leaves on the results channel. One item
//   per cycle is sustained while results is ready; the rate is set by the back
//   end, which does one entry's bound add and compare per cycle.
// Stalls:
//   When results is not ready the output register holds its result; the back
//   end stops, the queue fills, and items.ready drops once the queue is full.
// Reset:
//   Synchronous reset clears the queue, the output register valid, file_size,
//   the calibration flag and the parser phase, which then awaits a header.
//   The byte order resets to little endian.
// ----------------------------------------------------------------------------
module tiff_ifd_entry_classifier #(
  parameter int MAX_ENTRIES = tic_pkg::MAX_ENTRIES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  tic_item_if.sink                    items,
  tic_result_if.source                results,
  input  logic                        file_size_we,
  input  logic [tic_pkg::FSIZE_W-1:0] file_size_wdata
);
  import tic_pkg::*;

  // Queue handshake between the front end and the back end.
  logic    q_full;
  logic    q_push;
  q_item_t q_push_data;
  logic    q_pop;
  logic    q_valid;
  q_item_t q_data;

  // The front end does the state-free decoding: header byte order and magic,
  // and tag slot plus type size for both byte orders, so the back end only
  // has to select by the current byte order.
  tic_front u_front (
    .items      (items),
    .q_full     (q_full),
    .push_valid (q_push),
    .push_data  (q_push_data)
  );

  // Short queue that lets the front take items while the back stalls, until it is full.
  tic_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (q_push),
    .push_data  (q_push_data),
    .full       (q_full),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_data   (q_data)
  );

  // The back end owns the parser phase, directory position, entry countdown,
  // the sticky calibration flag and the output register.
  tic_back #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .file_size_we    (file_size_we),
    .file_size_wdata (file_size_wdata),
    .q_valid         (q_valid),
    .q_data          (q_data),
    .q_pop           (q_pop),
    .results         (results)
  );

`ifndef SYNTHESIS
  // Any error ends the directory, so the result must be marked last.
  assert property (@(posedge clk) disable iff (rst)
    results.valid && (results.status != ST_OK) |-> results.last)
    else $error("error result without last");

  // A slot is only reported for an entry that passed its checks.
  assert property (@(posedge clk) disable iff (rst)
    results.valid && (results.slot != SLOT_NONE) |-> (results.status == ST_OK))
    else $error("slot reported on a failed item");

  // A payload length only comes from a known field type.
  assert property (@(posedge clk) disable iff (rst)
    results.valid && (results.data_bytes != '0) |->
      (results.field_type != '0) && (results.field_type <= TYPE_DOUBLE))
    else $error("payload length with unknown field type");

  // The back end never takes an item from an empty queue.
  assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("queue popped while empty");
`endif

endmodule
